### sv/sep_pkg.sv
// Shared types and constants of the Sobel RGB edge magnitude block.
// Used by every module of the block; depends on nothing.
package sep_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // Widths of the frame registers and of the position counters.
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam int COL_W  = 11;
  localparam int ROW_W  = 14;
  localparam int ADDR_W = 10;
  localparam int CR_W   = 15;

  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET = 13'd768;
  localparam logic [FW_W-1:0] FW_MAX   = 11'd1024;
  localparam logic [FH_W-1:0] FH_MAX   = 13'd4096;

  // Configuration register indexes.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Item command codes.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // A root sum at or above this saturates the result.
  localparam logic [22:0] SAT_LIMIT = 23'd65281;
  localparam int          ROOT_STEPS = 8;

  typedef logic [23:0] pix_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       frame_last;
  } out_item_t;

  // Effective frame size after clamping.
  typedef struct packed {
    logic [FW_W-1:0] w;
    logic [FH_W-1:0] h;
  } dims_t;

  // One window to be evaluated; pixels outside the frame are already zero.
  typedef struct packed {
    logic [8:0][23:0] pix;
    logic             last;
  } job_t;

endpackage

### sv/sobel_edge_magnitude_rgb_top.sv
// Sobel RGB edge magnitude, top level: configuration registers, front end,
// job queue and back end. Depends on sep_pkg, sep_front, sep_jobq, sep_back.
//
// Pixels enter in raster order through push/full; results leave through
// empty/pop, one per window centre, trailing the input by one row plus one
// pixel, and drain items (cmd = 1) flush the last results of a frame. Each
// channel gives round(sqrt(Gx^2 + Gy^2)) saturated at 255, with pixels
// outside the frame taken as zero. The front end handles each item with a line
// store read, then a rotate and window shift that waits while the queue is full;
// an ignored drain needs only the read. The back end takes one job at a time
// (gradient, square, sum, eight root steps, output to a free result register),
// paced by the bit-serial root; a two-entry queue lets the front run ahead.
// Frame size registers are taken at once and should change only while idle.
// While reset is held, full and empty are high and cfg_ready is low.
// Line stores are not cleared after reset; entries never written are only
// read at masked edge positions.
module sobel_edge_magnitude_rgb_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  sep_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output sep_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data
);

  logic [sep_pkg::FW_W-1:0] frame_width_r;
  logic [sep_pkg::FH_W-1:0] frame_height_r;
  sep_pkg::dims_t           dims;
  logic                     job_push;
  logic                     job_full;
  logic                     job_pop;
  logic                     job_empty;
  sep_pkg::job_t            job_in;
  sep_pkg::job_t            job_out;

  assign cfg_ready = rst_n;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= sep_pkg::FW_RESET;
      frame_height_r <= sep_pkg::FH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sep_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[sep_pkg::FW_W-1:0];
        sep_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the frame size to the supported range.
  always_comb begin
    dims.w = (frame_width_r == '0) ? 11'd1
           : ((frame_width_r > sep_pkg::FW_MAX) ? sep_pkg::FW_MAX : frame_width_r);
    dims.h = (frame_height_r == '0) ? 13'd1
           : ((frame_height_r > sep_pkg::FH_MAX) ? sep_pkg::FH_MAX : frame_height_r);
  end

  sep_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .dims     (dims),
    .job_push (job_push),
    .job_full (job_full),
    .job      (job_in)
  );

  sep_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_in),
    .q_full  (job_full),
    .rd_en   (job_pop),
    .q_empty (job_empty),
    .rd_data (job_out)
  );

  sep_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (!job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

### sv/sep_jobq.sv
// Two-entry queue of window jobs between the front and the back.
// Depends on sep_pkg for the job type.
module sep_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  sep_pkg::job_t wr_data,
  output logic          q_full,
  input  logic          rd_en,
  output logic          q_empty,
  output sep_pkg::job_t rd_data
);

  sep_pkg::job_t mem_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  // Pointer and fill bookkeeping.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = ~wp_r;
    end
    if (rd_en) begin
      rp_nxt = ~rp_r;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage holds payload only.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

endmodule

### sv/sep_front.sv
// Front end: accepts items, tracks the raster position, keeps the line stores
// and the 3x3 window, and queues masked windows. Depends on sep_pkg.
module sep_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  sep_pkg::in_item_t in_data,
  input  sep_pkg::dims_t    dims,
  output logic              job_push,
  input  logic              job_full,
  output sep_pkg::job_t     job
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_MEM  = 2'b10
  } fstate_t;

  fstate_t                       state_r, state_nxt;
  logic [sep_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [sep_pkg::ROW_W-1:0]     row_r, row_nxt;
  sep_pkg::pix_t                 px_r;
  sep_pkg::pix_t                 top_rd_r;
  sep_pkg::pix_t                 mid_rd_r;
  logic [8:0][23:0]              win_r, win_nxt;
  sep_pkg::pix_t                 upper_mem [sep_pkg::MAX_WIDTH];
  sep_pkg::pix_t                 middle_mem [sep_pkg::MAX_WIDTH];

  logic                          accept;
  logic                          wrap;
  logic [sep_pkg::COL_W-1:0]     col_w;
  logic [sep_pkg::ROW_W-1:0]     row_w;
  logic                          in_frame;
  logic                          step;
  logic signed [sep_pkg::CR_W-1:0] cr;
  logic signed [sep_pkg::CR_W-1:0] h_s;
  logic [sep_pkg::COL_W-1:0]     cc;
  logic [sep_pkg::COL_W-1:0]     col_inc;
  logic                          cr_neg;
  logic                          cr_over;
  logic                          is_last;
  logic [2:0]                    row_ok;
  logic [2:0]                    col_ok;

  // The input stays closed while reset is held.
  assign accept = push && (state_r == F_IDLE);
  assign full   = !rst_n || (state_r != F_IDLE);
  assign step   = (state_r == F_MEM) && !job_full;

  // Position of the item being accepted, after a wrap left by a width change.
  always_comb begin
    wrap     = (col_r >= dims.w);
    col_w    = wrap ? '0 : col_r;
    row_w    = wrap ? row_r + 1'b1 : row_r;
    in_frame = (row_w < {1'b0, dims.h});
  end

  // Centre of the window that the current item completes.
  always_comb begin
    h_s     = $signed({2'b00, dims.h});
    if (col_r != '0) begin
      cr = $signed({1'b0, row_r}) - 15'sd1;
      cc = col_r - 1'b1;
    end else begin
      cr = $signed({1'b0, row_r}) - 15'sd2;
      cc = dims.w - 1'b1;
    end
    col_inc = col_r + 1'b1;
    cr_neg  = (cr < 0);
    cr_over = !cr_neg && (cr >= h_s);
    is_last = !cr_neg && !cr_over && (cr == h_s - 15'sd1) && (cc == dims.w - 1'b1);
    row_ok  = {(cr + 15'sd1 < h_s), 1'b1, (cr >= 15'sd1)};
    col_ok  = {(cc + 1'b1 < dims.w), 1'b1, (cc != '0)};
  end

  // Window shift: two columns move left, the new column enters on the right.
  always_comb begin
    win_nxt = win_r;
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = top_rd_r;
    win_nxt[5] = mid_rd_r;
    win_nxt[8] = px_r;
  end

  // Masked job for the back end.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      job.pix[k] = (row_ok[k/3] && col_ok[k%3]) ? win_nxt[k] : '0;
    end
    job.last = is_last;
    job_push = step && !cr_neg && !cr_over;
  end

  // Control sequencing and raster position.
  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          col_nxt = col_w;
          row_nxt = row_w;
          if (!(in_frame && in_data.cmd == sep_pkg::CMD_DRAIN)) begin
            state_nxt = F_MEM;
          end
        end
      end
      F_MEM: begin
        if (!job_full) begin
          state_nxt = F_IDLE;
          if (cr_over || is_last) begin
            col_nxt = '0;
            row_nxt = '0;
          end else if (col_inc >= dims.w) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
          end else begin
            col_nxt = col_inc;
          end
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (step) begin
        win_r <= win_nxt;
      end
    end
  end

  // Pixel latch; a pixel past the end of the frame counts as black.
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_frame ? {in_data.in_red, in_data.in_green, in_data.in_blue} : '0;
    end
  end

  // Line stores: read on accept, rotate on the following step.
  always_ff @(posedge clk) begin
    if (step) begin
      upper_mem[col_r[sep_pkg::ADDR_W-1:0]]  <= mid_rd_r;
      middle_mem[col_r[sep_pkg::ADDR_W-1:0]] <= px_r;
    end
    if (accept) begin
      top_rd_r <= upper_mem[col_w[sep_pkg::ADDR_W-1:0]];
      mid_rd_r <= middle_mem[col_w[sep_pkg::ADDR_W-1:0]];
    end
  end

endmodule

### sv/sep_back.sv
// Back end: Sobel gradients, squared sum and an iterative rounded root per
// channel, with a one-entry result register. Depends on sep_pkg.
module sep_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_avail,
  input  sep_pkg::job_t      job,
  output logic               job_pop,
  output logic               empty,
  input  logic               pop,
  output sep_pkg::out_item_t out_data
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_SQR  = 5'b00010,
    B_SUM  = 5'b00100,
    B_ROOT = 5'b01000,
    B_OUT  = 5'b10000
  } bstate_t;

  bstate_t                  state_r, state_nxt;
  logic [2:0]               cnt_r, cnt_nxt;
  logic                     last_r;
  logic signed [11:0]       gx_r [3];
  logic signed [11:0]       gy_r [3];
  logic [21:0]              sqx_r [3];
  logic [21:0]              sqy_r [3];
  logic [15:0]              s_r [3];
  logic                     sat_r [3];
  logic [9:0]               rem_r [3];
  logic [7:0]               q_r [3];
  logic                     out_valid_r;
  sep_pkg::out_item_t       out_data_r;

  logic signed [11:0]       gx [3];
  logic signed [11:0]       gy [3];
  logic [22:0]              sum [3];
  logic [11:0]              rem_sh [3];
  logic [11:0]              trial [3];
  logic [7:0]               res [3];

  // Gradients of each channel straight from the queue head.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic signed [11:0] p [9];
      for (int k = 0; k < 9; k++) begin
        p[k] = $signed({4'b0000, job.pix[k][ch*8 +: 8]});
      end
      gx[ch] = (p[2] + (p[5] <<< 1) + p[8]) - (p[0] + (p[3] <<< 1) + p[6]);
      gy[ch] = (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
    end
  end

  // Sum of squares and one root digit per channel.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch]    = {1'b0, sqx_r[ch]} + {1'b0, sqy_r[ch]};
      rem_sh[ch] = {rem_r[ch], s_r[ch][15:14]};
      trial[ch]  = {2'b00, q_r[ch], 2'b01};
      res[ch]    = sat_r[ch] ? 8'd255
                 : (({2'b00, q_r[ch]} < rem_r[ch]) ? q_r[ch] + 8'd1 : q_r[ch]);
    end
  end

  assign job_pop = (state_r == B_IDLE) && job_avail;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      B_IDLE: begin
        if (job_avail) begin
          state_nxt = B_SQR;
        end
      end
      B_SQR: begin
        state_nxt = B_SUM;
      end
      B_SUM: begin
        state_nxt = B_ROOT;
        cnt_nxt   = 3'(sep_pkg::ROOT_STEPS - 1);
      end
      B_ROOT: begin
        if (cnt_r == 3'd0) begin
          state_nxt = B_OUT;
        end else begin
          cnt_nxt = cnt_r - 3'd1;
        end
      end
      B_OUT: begin
        if (!out_valid_r) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == B_OUT && !out_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (job_pop) begin
        gx_r[ch] <= gx[ch];
        gy_r[ch] <= gy[ch];
      end
      if (state_r == B_SQR) begin
        sqx_r[ch] <= 22'(gx_r[ch] * gx_r[ch]);
        sqy_r[ch] <= 22'(gy_r[ch] * gy_r[ch]);
      end
      if (state_r == B_SUM) begin
        sat_r[ch] <= (sum[ch] >= sep_pkg::SAT_LIMIT);
        s_r[ch]   <= sum[ch][15:0];
        rem_r[ch] <= '0;
        q_r[ch]   <= '0;
      end
      if (state_r == B_ROOT) begin
        s_r[ch] <= {s_r[ch][13:0], 2'b00};
        if (rem_sh[ch] >= trial[ch]) begin
          rem_r[ch] <= 10'(rem_sh[ch] - trial[ch]);
          q_r[ch]   <= {q_r[ch][6:0], 1'b1};
        end else begin
          rem_r[ch] <= rem_sh[ch][9:0];
          q_r[ch]   <= {q_r[ch][6:0], 1'b0};
        end
      end
    end
    if (job_pop) begin
      last_r <= job.last;
    end
    if (state_r == B_OUT && !out_valid_r) begin
      out_data_r.out_blue   <= res[0];
      out_data_r.out_green  <= res[1];
      out_data_r.out_red    <= res[2];
      out_data_r.frame_last <= last_r;
    end
  end

  // No result is offered while reset is held.
  assign empty    = !out_valid_r || !rst_n;
  assign out_data = out_data_r;

endmodule

### sv/sep_chk.sv
// Port-level checker for the Sobel RGB edge magnitude block, with its bind.
// Depends on sep_pkg and on sobel_edge_magnitude_rgb_top.
module sep_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               push,
  input logic               full,
  input sep_pkg::in_item_t  in_data,
  input logic               empty,
  input logic               pop,
  input sep_pkg::out_item_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic               cfg_index,
  input logic [12:0]        cfg_data
);

  // Reset leaves no result waiting.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result waiting after reset");

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("waiting result changed before pop");

  // A pixel item always occupies the front for its line store step.
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full && in_data.cmd == sep_pkg::CMD_PIXEL |=> full)
    else $error("front took a second item during a line store cycle");

  // Right after reset release no result waits and the input is open.
  a_no_early: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> empty && !full)
    else $error("block not idle right after reset");

endmodule

bind sobel_edge_magnitude_rgb_top sep_chk u_sep_chk (.*);
